[rtl/jkgl_pkg.sv]
// shared constants and a helper for the gradient limiter
// widths of the fixed-point datapath and a bit-length function
// no dependencies
package jkgl_pkg;

  localparam int unsigned EPS_W     = 31;
  localparam int unsigned EPS_SQ_W  = 62;
  localparam int unsigned Q_W       = 64;
  localparam int unsigned BL_W      = 7;
  localparam int unsigned Q_KEEP    = 30;
  localparam int unsigned RCP_W     = 62;
  localparam int unsigned RCP_SUM_W = 64;
  localparam int unsigned R_KEEP    = 29;
  localparam int unsigned S_W       = 32;
  localparam int unsigned ACC_W     = 64;
  localparam int unsigned RND_W     = 33;

  localparam logic [EPS_W-1:0]    EPS_RESET    = 31'd16777;
  localparam logic [EPS_SQ_W-1:0] EPS_SQ_RESET =
    EPS_SQ_W'(64'(EPS_RESET) * 64'(EPS_RESET));
  localparam logic [RCP_W-1:0]    RCP_NUM      = RCP_W'(1) << (RCP_W - 1);

  function automatic logic [BL_W-1:0] bit_len(input logic [Q_W-1:0] v);
    logic [BL_W-1:0] n;
    n = '0;
    for (int i = 0; i < Q_W; i++) begin
      if (v[i]) begin
        n = BL_W'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

[rtl/jkgl_norm_lane.sv]
// one lane of the norm stage: squared magnitude plus epsilon squared
// two register stages, depends on jkgl_pkg
module jkgl_norm_lane import jkgl_pkg::*; #(
  parameter int unsigned GW = 32
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [GW-1:0]  grad_x_i,
  input  logic signed [GW-1:0]  grad_y_i,
  input  logic [EPS_SQ_W-1:0]   eps_sq_i,
  output logic [Q_W-1:0]        q_o
);

  logic [GW-1:0]   ax, ay;
  logic [2*GW-1:0] sx_q, sy_q;
  logic [Q_W-1:0]  q_q;

  always_comb begin
    ax = grad_x_i[GW-1] ? GW'(-grad_x_i) : grad_x_i;
    ay = grad_y_i[GW-1] ? GW'(-grad_y_i) : grad_y_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sx_q <= (2*GW)'(ax) * (2*GW)'(ax);
      sy_q <= (2*GW)'(ay) * (2*GW)'(ay);
      q_q  <= Q_W'(sx_q) + Q_W'(sy_q) + Q_W'(eps_sq_i);
    end
  end

  assign q_o = q_q;

endmodule

[rtl/jkgl_pipe_div.sv]
// pipelined restoring divider, one quotient bit per stage
// depends on nothing
module jkgl_pipe_div #(
  parameter int unsigned NUM_W = 64,
  parameter int unsigned DEN_W = 32,
  parameter int unsigned QUO_W = 33
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o
);

  localparam int unsigned CMP_W  = (NUM_W > DEN_W) ? NUM_W : DEN_W;
  localparam int unsigned WIDE_W = CMP_W + QUO_W;

  logic [NUM_W-1:0] rem_q [QUO_W-1];
  logic [DEN_W-1:0] den_q [QUO_W-1];
  logic [QUO_W-1:0] quo_q [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    localparam int unsigned B = QUO_W - 1 - s;
    logic [NUM_W-1:0]  rem_in;
    logic [DEN_W-1:0]  den_in;
    logic [QUO_W-1:0]  quo_in;
    logic [CMP_W-1:0]  top, dv;
    logic [WIDE_W-1:0] shifted;
    logic              take;

    if (s == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    always_comb begin
      top     = CMP_W'(rem_in >> B);
      dv      = CMP_W'(den_in);
      take    = (top >= dv);
      shifted = WIDE_W'(den_in) << B;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[s] <= quo_in | (take ? (QUO_W'(1) << B) : '0);
      end
    end

    if (s < QUO_W - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s] <= take ? (rem_in - shifted[NUM_W-1:0]) : rem_in;
          den_q[s] <= den_in;
        end
      end
    end
  end

  assign quo_o = quo_q[QUO_W-1];

endmodule

[rtl/jk_gradient_limiter_unit.sv]
// top level of the product-weight gradient limiter
// parallel norm lanes and reciprocal dividers, merge, weighted sum, rounding divide
// depends on jkgl_pkg, jkgl_norm_lane, jkgl_pipe_div
//
// One cell is accepted per cycle unless a valid result is held by a stall on the
// output; such a stall freezes the whole pipeline. The reciprocal divider of each
// lane has 62 stages and the rounding divider of each component has 33 stages.
// The epsilon register may be written only while no transaction is in flight.
module jk_gradient_limiter_unit import jkgl_pkg::*; #(
  parameter int unsigned GRAD_BITS = 32,
  parameter int unsigned MAX_EDGES = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [EPS_W-1:0]            cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [GRAD_BITS-1:0] self_grad_x_i,
  input  logic signed [GRAD_BITS-1:0] self_grad_y_i,
  input  logic signed [GRAD_BITS-1:0] nbr0_grad_x_i,
  input  logic signed [GRAD_BITS-1:0] nbr0_grad_y_i,
  input  logic signed [GRAD_BITS-1:0] nbr1_grad_x_i,
  input  logic signed [GRAD_BITS-1:0] nbr1_grad_y_i,
  input  logic signed [GRAD_BITS-1:0] nbr2_grad_x_i,
  input  logic signed [GRAD_BITS-1:0] nbr2_grad_y_i,
  input  logic signed [GRAD_BITS-1:0] nbr3_grad_x_i,
  input  logic signed [GRAD_BITS-1:0] nbr3_grad_y_i,
  input  logic [3:0]                  nbr_present_mask_i,
  input  logic                        is_quad_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [GRAD_BITS-1:0] limited_grad_x_o,
  output logic signed [GRAD_BITS-1:0] limited_grad_y_o
);

  localparam int unsigned GW = (GRAD_BITS > 32) ? 32 : GRAD_BITS;
  localparam int unsigned NT = MAX_EDGES + 1;

  localparam int unsigned ST_Q    = 2;
  localparam int unsigned ST_MIN  = 3;
  localparam int unsigned ST_SH   = 4;
  localparam int unsigned ST_RCP  = ST_SH + RCP_W;
  localparam int unsigned ST_SUM  = ST_RCP + 1;
  localparam int unsigned ST_RS   = ST_SUM + 1;
  localparam int unsigned ST_PROD = ST_RS + 1;
  localparam int unsigned ST_ACC  = ST_PROD + 1;
  localparam int unsigned ST_NUM  = ST_ACC + 1;
  localparam int unsigned ST_DIV  = ST_NUM + RND_W;
  localparam int unsigned ST_OUT  = ST_DIV + 1;

  localparam logic [RND_W-1:0] HI = (RND_W'(1) << (GW - 1)) - RND_W'(1);
  localparam int unsigned P_W = R_KEEP + GW + 1;

  logic en;
  logic v_q [ST_OUT+1];

  logic [EPS_W-1:0]    eps_q;
  logic [EPS_SQ_W-1:0] eps_sq_q;

  logic [NT-1:0][GW-1:0] gx_q [ST_RS+1];
  logic [NT-1:0][GW-1:0] gy_q [ST_RS+1];
  logic [NT-1:0]         act_q [ST_RS+1];
  logic [NT-1:0][GW-1:0] gx_in, gy_in;
  logic [NT-1:0]         act_in;

  logic [Q_W-1:0]   q_w   [NT];
  logic [Q_W-1:0]   qc_q  [NT];
  logic [Q_W-1:0]   qs_q  [NT];
  logic [Q_W-1:0]   qm_q;
  logic [RCP_W-1:0] rcp_w [NT];
  logic [RCP_W-1:0] rc_q  [NT];
  logic [RCP_SUM_W-1:0] sum_q;
  logic [R_KEEP-1:0]    rs_q [NT];
  logic signed [ACC_W-1:0] px_q [NT];
  logic signed [ACC_W-1:0] py_q [NT];
  logic [S_W-1:0]  s_prod_q, s_acc_q, s_num_q;
  logic signed [ACC_W-1:0] accx_q, accy_q;
  logic [ACC_W-1:0] numx_q, numy_q;
  logic [RND_W-1:0] quox_w, quoy_w;
  logic zero_q [ST_MIN:ST_DIV];
  logic negx_q [ST_NUM:ST_DIV];
  logic negy_q [ST_NUM:ST_DIV];
  logic [GW-1:0] outx_q, outy_q;

  assign en          = !(v_q[ST_OUT] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = v_q[ST_OUT];

  // control and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= ST_OUT; i++) begin
        v_q[i] <= 1'b0;
      end
      eps_q    <= EPS_RESET;
      eps_sq_q <= EPS_SQ_RESET;
    end else begin
      if (en) begin
        v_q[0] <= in_valid_i;
        for (int i = 1; i <= ST_OUT; i++) begin
          v_q[i] <= v_q[i-1];
        end
      end
      if (cfg_we_i) begin
        eps_q <= cfg_wdata_i;
      end
      eps_sq_q <= EPS_SQ_W'(eps_q) * EPS_SQ_W'(eps_q);
    end
  end

  // absent neighbours mirror the cell's own gradient
  always_comb begin
    logic [3:0][GW-1:0] nx, ny;
    nx[0] = nbr0_grad_x_i[GW-1:0];
    ny[0] = nbr0_grad_y_i[GW-1:0];
    nx[1] = nbr1_grad_x_i[GW-1:0];
    ny[1] = nbr1_grad_y_i[GW-1:0];
    nx[2] = nbr2_grad_x_i[GW-1:0];
    ny[2] = nbr2_grad_y_i[GW-1:0];
    nx[3] = nbr3_grad_x_i[GW-1:0];
    ny[3] = nbr3_grad_y_i[GW-1:0];
    gx_in[0]  = self_grad_x_i[GW-1:0];
    gy_in[0]  = self_grad_y_i[GW-1:0];
    act_in[0] = 1'b1;
    for (int k = 1; k < NT; k++) begin
      gx_in[k]  = nbr_present_mask_i[k-1] ? nx[k-1] : self_grad_x_i[GW-1:0];
      gy_in[k]  = nbr_present_mask_i[k-1] ? ny[k-1] : self_grad_y_i[GW-1:0];
      act_in[k] = (k < 4) ? 1'b1 : is_quad_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      gx_q[0]  <= gx_in;
      gy_q[0]  <= gy_in;
      act_q[0] <= act_in;
      for (int i = 1; i <= ST_RS; i++) begin
        gx_q[i]  <= gx_q[i-1];
        gy_q[i]  <= gy_q[i-1];
        act_q[i] <= act_q[i-1];
      end
    end
  end

  for (genvar k = 0; k < NT; k++) begin : g_lane
    jkgl_norm_lane #(
      .GW (GW)
    ) u_norm (
      .clk_i    (clk_i),
      .en_i     (en),
      .grad_x_i ($signed(gx_q[0][k])),
      .grad_y_i ($signed(gy_q[0][k])),
      .eps_sq_i (eps_sq_q),
      .q_o      (q_w[k])
    );

    jkgl_pipe_div #(
      .NUM_W (RCP_W),
      .DEN_W (Q_W),
      .QUO_W (RCP_W)
    ) u_rcp (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (RCP_NUM),
      .den_i (qs_q[k]),
      .quo_o (rcp_w[k])
    );
  end

  // merge: smallest norm, common scaling, reciprocal sum, weight scaling, lane products, rounding numerators
  always_ff @(posedge clk_i) begin
    logic [Q_W-1:0]       qmin;
    logic                 zero;
    logic [BL_W-1:0]      bl, bl_s;
    logic [RCP_SUM_W-1:0] rsum;
    logic [S_W-1:0]       ssum;
    logic signed [P_W-1:0] p;
    logic [ACC_W-1:0]     ax, ay;
    if (en) begin
      qmin = q_w[0];
      zero = (q_w[0] == '0);
      for (int k = 1; k < NT; k++) begin
        if (act_q[ST_Q][k]) begin
          if (q_w[k] < qmin) begin
            qmin = q_w[k];
          end
          if (q_w[k] == '0) begin
            zero = 1'b1;
          end
        end
      end
      qm_q           <= qmin;
      zero_q[ST_MIN] <= zero;
      for (int i = ST_MIN + 1; i <= ST_DIV; i++) begin
        zero_q[i] <= zero_q[i-1];
      end
      for (int k = 0; k < NT; k++) begin
        qc_q[k] <= q_w[k];
      end

      bl = bit_len(qm_q);
      bl_s = (bl > BL_W'(Q_KEEP)) ? (bl - BL_W'(Q_KEEP)) : '0;
      for (int k = 0; k < NT; k++) begin
        qs_q[k] <= qc_q[k] >> bl_s;
      end

      rsum = '0;
      for (int k = 0; k < NT; k++) begin
        rc_q[k] <= rcp_w[k];
        if (act_q[ST_RCP][k]) begin
          rsum = rsum + RCP_SUM_W'(rcp_w[k]);
        end
      end
      sum_q <= rsum;

      bl = bit_len(sum_q);
      bl_s = (bl > BL_W'(R_KEEP)) ? (bl - BL_W'(R_KEEP)) : '0;
      for (int k = 0; k < NT; k++) begin
        rs_q[k] <= R_KEEP'(rc_q[k] >> bl_s);
      end

      ssum = '0;
      for (int k = 0; k < NT; k++) begin
        if (act_q[ST_RS][k]) begin
          ssum  = ssum + S_W'(rs_q[k]);
          p     = $signed({1'b0, rs_q[k]}) * $signed(gx_q[ST_RS][k]);
          px_q[k] <= ACC_W'(p);
          p     = $signed({1'b0, rs_q[k]}) * $signed(gy_q[ST_RS][k]);
          py_q[k] <= ACC_W'(p);
        end else begin
          px_q[k] <= '0;
          py_q[k] <= '0;
        end
      end
      s_prod_q <= (ssum == '0) ? S_W'(1) : ssum;

      s_acc_q <= s_prod_q;

      ax = accx_q[ACC_W-1] ? ACC_W'(-accx_q) : ACC_W'(accx_q);
      ay = accy_q[ACC_W-1] ? ACC_W'(-accy_q) : ACC_W'(accy_q);
      numx_q         <= ax + ACC_W'(s_acc_q >> 1);
      numy_q         <= ay + ACC_W'(s_acc_q >> 1);
      negx_q[ST_NUM] <= accx_q[ACC_W-1];
      negy_q[ST_NUM] <= accy_q[ACC_W-1];
      for (int i = ST_NUM + 1; i <= ST_DIV; i++) begin
        negx_q[i] <= negx_q[i-1];
        negy_q[i] <= negy_q[i-1];
      end
      s_num_q        <= s_acc_q;
    end
  end

  // weighted sums of the lane products
  logic signed [ACC_W-1:0] sumx, sumy;
  always_comb begin
    sumx = '0;
    sumy = '0;
    for (int k = 0; k < NT; k++) begin
      sumx = sumx + px_q[k];
      sumy = sumy + py_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      accx_q <= sumx;
      accy_q <= sumy;
    end
  end

  jkgl_pipe_div #(
    .NUM_W (ACC_W),
    .DEN_W (S_W),
    .QUO_W (RND_W)
  ) u_rnd_x (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (numx_q),
    .den_i (s_num_q),
    .quo_o (quox_w)
  );

  jkgl_pipe_div #(
    .NUM_W (ACC_W),
    .DEN_W (S_W),
    .QUO_W (RND_W)
  ) u_rnd_y (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (numy_q),
    .den_i (s_num_q),
    .quo_o (quoy_w)
  );

  function automatic logic [GW-1:0] finish(input logic [RND_W-1:0] q, input logic neg,
                                           input logic zero);
    logic [GW-1:0]    res;
    logic [RND_W-1:0] nq;
    nq = RND_W'(-q);
    if (zero) begin
      res = '0;
    end else if (!neg) begin
      res = (q > HI) ? HI[GW-1:0] : q[GW-1:0];
    end else if (q > HI + RND_W'(1)) begin
      res = GW'(1) << (GW - 1);
    end else begin
      res = nq[GW-1:0];
    end
    return res;
  endfunction

  always_ff @(posedge clk_i) begin
    if (en) begin
      outx_q <= finish(quox_w, negx_q[ST_DIV], zero_q[ST_DIV]);
      outy_q <= finish(quoy_w, negy_q[ST_DIV], zero_q[ST_DIV]);
    end
  end

  assign limited_grad_x_o = GRAD_BITS'(outx_q);
  assign limited_grad_y_o = GRAD_BITS'(outy_q);

endmodule

[tb/tb_jk_gradient_limiter_unit.sv]
// self-checking testbench for jk_gradient_limiter_unit: directed table, then random cells
// under bursty input and patterned output stalls, checked against expected table values
// or an in-bench predictor; depends on jkgl_pkg and the rtl of jk_gradient_limiter_unit
module tb_jk_gradient_limiter_unit import jkgl_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned GW = 32;
  localparam logic [EPS_W-1:0] EPS_MAX = '1;

  typedef struct {
    logic signed [GW-1:0] g [10];
    logic [3:0]           mask;
    logic                 quad;
  } cell_t;

  typedef struct {
    logic signed [GW-1:0] x;
    logic signed [GW-1:0] y;
  } grad_t;

  typedef struct {
    cell_t c;
    bit    typed;
    grad_t res;
  } row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [EPS_W-1:0]     cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic signed [GW-1:0] grad_in [10];
  logic [3:0]           nbr_present_mask_i = '0;
  logic                 is_quad_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic signed [GW-1:0] limited_grad_x_o;
  logic signed [GW-1:0] limited_grad_y_o;

  logic [EPS_W-1:0] eps_model = EPS_RESET;
  grad_t            pending_grads [$];
  int               mismatches = 0;
  int               cells_sent = 0;
  int               results_seen = 0;
  int               burst_left = 4;
  int               stall_mode = 0;
  int               stall_cnt = 0;

  initial for (int i = 0; i < 10; i++) grad_in[i] = '0;

  jk_gradient_limiter_unit uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .self_grad_x_i(grad_in[0]), .self_grad_y_i(grad_in[1]),
    .nbr0_grad_x_i(grad_in[2]), .nbr0_grad_y_i(grad_in[3]),
    .nbr1_grad_x_i(grad_in[4]), .nbr1_grad_y_i(grad_in[5]),
    .nbr2_grad_x_i(grad_in[6]), .nbr2_grad_y_i(grad_in[7]),
    .nbr3_grad_x_i(grad_in[8]), .nbr3_grad_y_i(grad_in[9]),
    .nbr_present_mask_i, .is_quad_i, .out_valid_o, .out_stall_i,
    .limited_grad_x_o, .limited_grad_y_o
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("tb_jk_gradient_limiter_unit: done, errors");
    $finish;
  end

  function automatic int blen(input logic [63:0] v);
    int n;
    n = 0;
    for (int i = 0; i < 64; i++) if (v[i]) n = i + 1;
    return n;
  endfunction

  function automatic logic [63:0] absv(input logic signed [63:0] v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [GW-1:0] blend(input logic [63:0] r [5],
      input logic signed [63:0] g [5], input int n, input logic [63:0] s);
    logic signed [63:0] acc;
    logic signed [63:0] res;
    logic [63:0] m;
    logic [63:0] q;
    acc = '0;
    for (int k = 0; k < n; k++) acc += $signed(r[k]) * g[k];
    m = absv(acc);
    q = (m + s / 2) / s;
    if (q > 64'h8000_0000) q = 64'h8000_0000;
    res = acc < 0 ? -$signed(q) : $signed(q);
    if (res > 64'sh7FFF_FFFF) res = 64'sh7FFF_FFFF;
    if (res < -64'sh8000_0000) res = -64'sh8000_0000;
    return res[GW-1:0];
  endfunction

  function automatic grad_t limit_cell(input cell_t c, input logic [EPS_W-1:0] eps);
    logic signed [63:0] gx [5];
    logic signed [63:0] gy [5];
    logic [63:0] q [5];
    logic [63:0] r [5];
    logic [63:0] eps2, qmin, total, s, ax, ay;
    int n, sh, u;
    bit zero;
    grad_t o;
    eps2 = 64'(eps) * 64'(eps);
    n = c.quad ? 5 : 4;
    zero = 1'b0;
    gx[0] = c.g[0];
    gy[0] = c.g[1];
    for (int k = 1; k < n; k++) begin
      gx[k] = c.mask[k-1] ? 64'(c.g[2*k]) : gx[0];
      gy[k] = c.mask[k-1] ? 64'(c.g[2*k+1]) : gy[0];
    end
    for (int k = 0; k < n; k++) begin
      ax = absv(gx[k]);
      ay = absv(gy[k]);
      q[k] = ax * ax + ay * ay + eps2;
      if (q[k] == 0) zero = 1'b1;
    end
    if (zero) begin
      o.x = '0;
      o.y = '0;
      return o;
    end
    qmin = q[0];
    for (int k = 1; k < n; k++) if (q[k] < qmin) qmin = q[k];
    sh = blen(qmin) - 30;
    if (sh < 0) sh = 0;
    total = '0;
    for (int k = 0; k < n; k++) begin
      r[k] = (64'd1 << 61) / (q[k] >> sh);
      total += r[k];
    end
    u = blen(total) - 29;
    if (u < 0) u = 0;
    s = '0;
    for (int k = 0; k < n; k++) begin
      r[k] = r[k] >> u;
      s += r[k];
    end
    if (s == 0) s = 64'd1;
    o.x = blend(r, gx, n, s);
    o.y = blend(r, gy, n, s);
    return o;
  endfunction

  task automatic report(input string what, input logic [GW-1:0] got, input logic [GW-1:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // receiver: stall pattern and result check
  always @(posedge clk_i) begin
    grad_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_grads.size() == 0) begin
        report("unexpected transaction", limited_grad_x_o, '0);
      end else begin
        e = pending_grads.pop_front();
        if (limited_grad_x_o !== e.x) report("limited_grad_x", limited_grad_x_o, e.x);
        if (limited_grad_y_o !== e.y) report("limited_grad_y", limited_grad_y_o, e.y);
      end
    end
    if (stall_cnt == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_cnt = $urandom_range(10, 60);
    end
    stall_cnt--;
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= (stall_cnt % 5) < 2;
      default: out_stall_i <= ($urandom_range(0, 1) == 0);
    endcase
  end

  task automatic send_cell(input cell_t c, input bit typed, input grad_t res);
    grad_t e;
    for (int i = 0; i < 10; i++) grad_in[i] <= c.g[i];
    nbr_present_mask_i <= c.mask;
    is_quad_i <= c.quad;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    if (typed) begin
      e = res;
    end else begin
      e = limit_cell(c, eps_model);
    end
    pending_grads.push_back(e);
    cells_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 30);
    end
  endtask

  task automatic write_eps(input logic [EPS_W-1:0] v);
    in_valid_i <= 1'b0;
    while (pending_grads.size() != 0) @(posedge clk_i);
    repeat (110) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    eps_model = v;
  endtask

  function automatic logic signed [GW-1:0] rand_grad();
    case ($urandom_range(0, 5))
      0: return $signed(32'($urandom_range(0, 255)) - 128);
      1: return $signed({{8{$urandom_range(0, 1) == 1}}, 24'($urandom)});
      2: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $signed(32'($urandom));
    endcase
  endfunction

  function automatic cell_t rand_cell();
    cell_t c;
    for (int i = 0; i < 10; i++) c.g[i] = rand_grad();
    if ($urandom_range(0, 7) == 0) for (int i = 2; i < 10; i++) c.g[i] = c.g[i % 2];
    c.mask = 4'($urandom);
    c.quad = 1'($urandom_range(0, 1));
    return c;
  endfunction

  function automatic row_t uniform_row(input logic signed [GW-1:0] gx,
      input logic signed [GW-1:0] gy, input logic [3:0] mask, input logic quad);
    row_t r;
    for (int i = 0; i < 10; i += 2) begin
      r.c.g[i] = gx;
      r.c.g[i+1] = gy;
    end
    r.c.mask = mask;
    r.c.quad = quad;
    r.typed = 1'b1;
    r.res.x = gx;
    r.res.y = gy;
    return r;
  endfunction

  initial begin
    row_t rows [$];
    row_t r;
    logic [EPS_W-1:0] eps_set [5];
    grad_t none;
    none.x = '0;
    none.y = '0;
    eps_set = '{EPS_RESET, '0, EPS_MAX, 31'd1, 31'd16777216};

    // directed table: identical gradients give themselves back, absent neighbours mirror self
    rows.push_back(uniform_row('0, '0, 4'hF, 1'b1));
    rows.push_back(uniform_row(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 4'hF, 1'b1));
    rows.push_back(uniform_row(32'sh8000_0000, 32'sh8000_0000, 4'hF, 1'b0));
    rows.push_back(uniform_row(32'sh7FFF_FFFF, 32'sh8000_0000, 4'h7, 1'b0));
    rows.push_back(uniform_row(32'sh0100_0000, -32'sh0100_0000, 4'h5, 1'b1));
    rows.push_back(uniform_row(-32'sd1, 32'sd1, 4'hA, 1'b1));
    for (int k = 0; k < 6; k++) begin
      r = uniform_row(rand_grad(), rand_grad(), 4'h0, k[0]);
      for (int i = 2; i < 10; i++) r.c.g[i] = rand_grad();
      rows.push_back(r);
    end
    // triangle ignores edge 3 even when its mask bit is set
    r = uniform_row(32'sh0123_4567, -32'sh0765_4321, 4'hF, 1'b0);
    r.c.g[8] = 32'sh8000_0000;
    r.c.g[9] = 32'sh7FFF_FFFF;
    rows.push_back(r);
    for (int k = 0; k < 8; k++) begin
      r.c = rand_cell();
      r.typed = 1'b0;
      rows.push_back(r);
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (rows[i]) send_cell(rows[i].c, rows[i].typed, rows[i].res);

    for (int p = 1; p < 8; p++) begin
      write_eps(p < 5 ? eps_set[p] : 31'($urandom));
      if (eps_model == '0) begin
        // zero norm cells
        r = uniform_row('0, '0, 4'h0, 1'b1);
        send_cell(r.c, 1'b1, none);
        r = uniform_row('0, '0, 4'hF, 1'b0);
        r.c.g[2] = 32'sh0100_0000;
        send_cell(r.c, 1'b1, none);
      end
      for (int k = 0; k < 210; k++) send_cell(rand_cell(), 1'b0, none);
    end

    in_valid_i <= 1'b0;
    while (pending_grads.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
    $display("covered %0d cells, %0d results, 8 epsilon settings incl. 0 and max",
             cells_sent, results_seen);
    if (mismatches == 0 && pending_grads.size() == 0) begin
      $display("tb_jk_gradient_limiter_unit: done, clean");
    end else begin
      $display("tb_jk_gradient_limiter_unit: done, errors");
    end
    $finish;
  end

endmodule

[jk_gradient_limiter_unit.f]
rtl/jkgl_pkg.sv
rtl/jkgl_norm_lane.sv
rtl/jkgl_pipe_div.sv
rtl/jk_gradient_limiter_unit.sv
tb/tb_jk_gradient_limiter_unit.sv
